// ===== sv/elr_pkg.sv =====
// Shared types and constants for the enquiry/acknowledge link receiver.
// Holds the beat structs, control byte codes, status codes and register indexes.
// No dependencies.
package elr_pkg;

	// Register and field widths.
	localparam int TICK_W  = 16;
	localparam int CAP_W   = 9;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 3;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 16;

	// Control bytes of the link.
	localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
	localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
	localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
	localparam logic [BYTE_W-1:0] CH_ENQ = 8'h05;
	localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
	localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;

	// Transaction status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_CLOSED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd2;
	localparam logic [STAT_W-1:0] ST_ABORTED = 3'd3;
	localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_ENQ_TIMEOUT  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BYTE_TIMEOUT = 2'd1;
	localparam logic [CIDX_W-1:0] REG_EOT_TIMEOUT  = 2'd2;
	localparam logic [CIDX_W-1:0] REG_CAPACITY     = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [TICK_W-1:0] RST_ENQ_TIMEOUT  = 16'd0;
	localparam logic [TICK_W-1:0] RST_BYTE_TIMEOUT = 16'd1000;
	localparam logic [TICK_W-1:0] RST_EOT_TIMEOUT  = 16'd1000;
	localparam logic [CAP_W-1:0]  RST_CAPACITY     = 9'd256;

	// Link phases.
	typedef enum logic [1:0] {
		PH_ENQ,
		PH_STX,
		PH_TEXT,
		PH_CLOSE
	} phase_t;

	// Input beat: a received byte or one tick.
	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] rx_byte;
	} in_beat_t;

	// Result beat.
	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              data_valid;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] data_index;
		logic              frame_discard;
		logic              done_res;
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] payload_length;
	} out_beat_t;

	// Configuration register set.
	typedef struct packed {
		logic [TICK_W-1:0] enq_timeout;
		logic [TICK_W-1:0] byte_timeout;
		logic [TICK_W-1:0] eot_timeout;
		logic [CAP_W-1:0]  capacity;
	} cfg_t;

	// Handshake between the input register and the result register.
	typedef struct packed {
		logic valid;
		logic ready;
	} stage_ctl_t;

endpackage

// ===== sv/elr_cfg_regs.sv =====
// Configuration register file of the link receiver.
// Four registers written by index over a valid/ready channel.
// Depends on elr_pkg.
module elr_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [elr_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [elr_pkg::CDATA_W-1:0]  cfg_data,
	output elr_pkg::cfg_t                cfg
);

	elr_pkg::cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register write by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enq_timeout  <= elr_pkg::RST_ENQ_TIMEOUT;
			cfg_q.byte_timeout <= elr_pkg::RST_BYTE_TIMEOUT;
			cfg_q.eot_timeout  <= elr_pkg::RST_EOT_TIMEOUT;
			cfg_q.capacity     <= elr_pkg::RST_CAPACITY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				elr_pkg::REG_ENQ_TIMEOUT:  cfg_q.enq_timeout  <= cfg_data;
				elr_pkg::REG_BYTE_TIMEOUT: cfg_q.byte_timeout <= cfg_data;
				elr_pkg::REG_EOT_TIMEOUT:  cfg_q.eot_timeout  <= cfg_data;
				elr_pkg::REG_CAPACITY:     cfg_q.capacity     <= cfg_data[elr_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/elr_in_reg.sv =====
// Input register of the link receiver.
// Holds one beat until the link state machine consumes it.
// Depends on elr_pkg.
module elr_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  elr_pkg::in_beat_t   in_data,
	input  logic                down_ready,
	output elr_pkg::stage_ctl_t s1_ctl,
	output elr_pkg::in_beat_t   beat_s1
);

	logic valid_s1;
	logic accept;
	logic go;

	// The held beat leaves when the result side can take it.
	assign s1_ctl.valid = valid_s1;
	assign s1_ctl.ready = down_ready;
	assign go           = valid_s1 && down_ready;
	assign in_stall     = valid_s1 && !down_ready;
	assign accept       = in_valid && !in_stall;

	// Valid flag of the held beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Held beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= in_data;
		end
	end

endmodule

// ===== sv/elr_fsm.sv =====
// Link state machine of the receiver: phase, tick counter and byte counter.
// Turns one input beat into at most one result beat, combinationally.
// Depends on elr_pkg.
module elr_fsm #(
	parameter int CAPACITY_MAX = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  elr_pkg::in_beat_t   beat_s1,
	input  elr_pkg::cfg_t       cfg,
	output logic                res_valid,
	output elr_pkg::out_beat_t  res
);

	localparam int CAPMAX_BITS = $clog2(CAPACITY_MAX + 1);
	localparam int CW = (CAPMAX_BITS > elr_pkg::CAP_W) ? CAPMAX_BITS : elr_pkg::CAP_W;

	elr_pkg::phase_t                phase_q, phase_d;
	logic [elr_pkg::TICK_W-1:0]     tick_q, tick_d, tick_inc;
	logic [elr_pkg::CAP_W-1:0]      count_q, count_d, count_inc;
	logic [CW-1:0]                  cap_raw, cap_eff;
	logic [elr_pkg::TICK_W-1:0]     byte_lim, eot_lim;
	logic                           enq_exp, byte_exp, eot_exp;
	logic [elr_pkg::BYTE_W-1:0]     b;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= elr_pkg::PH_ENQ;
			tick_q  <= '0;
			count_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			count_q <= count_d;
		end
	end

	// Effective capacity clamped to one and to the buffer size.
	always_comb begin
		cap_raw = CW'(cfg.capacity);
		if (cap_raw == '0) begin
			cap_eff = CW'(1);
		end else if (cap_raw > CW'(CAPACITY_MAX)) begin
			cap_eff = CW'(CAPACITY_MAX);
		end else begin
			cap_eff = cap_raw;
		end
	end

	// Saturating tick advance and limit compares; a zero byte or close limit acts as one.
	assign tick_inc  = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
	assign byte_lim  = (cfg.byte_timeout == '0) ? elr_pkg::TICK_W'(1) : cfg.byte_timeout;
	assign eot_lim   = (cfg.eot_timeout == '0) ? elr_pkg::TICK_W'(1) : cfg.eot_timeout;
	assign enq_exp   = tick_inc >= cfg.enq_timeout;
	assign byte_exp  = tick_inc >= byte_lim;
	assign eot_exp   = tick_inc >= eot_lim;
	assign count_inc = count_q + 1'b1;
	assign b         = beat_s1.rx_byte;

	// Next state and result for the current beat.
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		count_d = count_q;
		res     = '0;
		if (beat_s1.op) begin
			// One time tick.
			case (phase_q)
				elr_pkg::PH_ENQ: begin
					if (cfg.enq_timeout != '0) begin
						tick_d = tick_inc;
						if (enq_exp) begin
							res.done_res = 1'b1;
							res.status   = elr_pkg::ST_TIMEOUT;
						end
					end
				end
				elr_pkg::PH_STX, elr_pkg::PH_TEXT: begin
					tick_d = tick_inc;
					if (byte_exp) begin
						res.tx_valid = 1'b1;
						res.tx_byte  = elr_pkg::CH_EOT;
						res.done_res = 1'b1;
						res.status   = elr_pkg::ST_TIMEOUT;
					end
				end
				default: begin
					tick_d = tick_inc;
					if (eot_exp) begin
						res.done_res       = 1'b1;
						res.status         = elr_pkg::ST_OK;
						res.payload_length = count_q[elr_pkg::BYTE_W-1:0];
					end
				end
			endcase
		end else begin
			// One received byte.
			tick_d = '0;
			case (phase_q)
				elr_pkg::PH_ENQ: begin
					if (b == elr_pkg::CH_EOT) begin
						res.done_res = 1'b1;
						res.status   = elr_pkg::ST_CLOSED;
					end else if (b == elr_pkg::CH_ENQ) begin
						res.tx_valid = 1'b1;
						res.tx_byte  = elr_pkg::CH_ACK;
						phase_d      = elr_pkg::PH_STX;
					end
				end
				elr_pkg::PH_STX: begin
					if (b == elr_pkg::CH_STX) begin
						count_d = '0;
						phase_d = elr_pkg::PH_TEXT;
					end else begin
						res.done_res = 1'b1;
						res.status   = (b == elr_pkg::CH_EOT) ? elr_pkg::ST_ABORTED
						                                      : elr_pkg::ST_INVALID;
					end
				end
				elr_pkg::PH_TEXT: begin
					if (b == elr_pkg::CH_ETX) begin
						res.tx_valid = 1'b1;
						res.tx_byte  = elr_pkg::CH_ACK;
						phase_d      = elr_pkg::PH_CLOSE;
					end else begin
						res.data_valid = 1'b1;
						res.data_byte  = b;
						res.data_index = count_q[elr_pkg::BYTE_W-1:0];
						count_d        = count_inc;
						if (CW'(count_inc) >= cap_eff) begin
							res.tx_valid      = 1'b1;
							res.tx_byte       = elr_pkg::CH_NAK;
							res.frame_discard = 1'b1;
							count_d           = '0;
							phase_d           = elr_pkg::PH_STX;
						end
					end
				end
				default: begin
					res.done_res       = 1'b1;
					res.status         = elr_pkg::ST_OK;
					res.payload_length = count_q[elr_pkg::BYTE_W-1:0];
				end
			endcase
		end
		// Every ending returns to the enquiry wait with both counts cleared.
		if (res.done_res) begin
			phase_d = elr_pkg::PH_ENQ;
			tick_d  = '0;
			count_d = '0;
		end
	end

	assign res_valid = res.tx_valid || res.data_valid || res.done_res;

endmodule

// ===== sv/elr_out_reg.sv =====
// Result register of the link receiver.
// Holds one result beat until the downstream side takes it.
// Depends on elr_pkg.
module elr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  elr_pkg::out_beat_t  res,
	output logic                ready,
	output logic                out_valid,
	input  logic                out_stall,
	output elr_pkg::out_beat_t  out_data
);

	logic               valid_q;
	elr_pkg::out_beat_t data_q;

	// Room for a new result when empty or when the held one leaves now.
	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

endmodule

// ===== sv/enq_ack_link_receiver.sv =====
// Top level of the enquiry/acknowledge link receiver.
// Instantiates elr_cfg_regs, elr_in_reg, elr_fsm and elr_out_reg; depends on elr_pkg.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_stall  | in_data  (op, rx_byte)
//   out     | output    | out_valid / out_stall| out_data (tx, data, done fields)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; a beat goes through the input
// register, the state machine logic and the result register, and out_valid rises once
// the result is loaded into the result register.
// Beats that produce no result leave no output beat.
// Reset clears phase, counters and valid flags at once; there is no clearing pass.
// A stalled result holds in the result register while one more beat waits in the
// input register; only then is the input stalled.
module enq_ack_link_receiver #(
	parameter int CAPACITY_MAX = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  elr_pkg::in_beat_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output elr_pkg::out_beat_t           out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [elr_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [elr_pkg::CDATA_W-1:0]  cfg_data
);

	elr_pkg::cfg_t       cfg;
	elr_pkg::in_beat_t   beat_s1;
	elr_pkg::out_beat_t  res;
	elr_pkg::stage_ctl_t s1_ctl;
	logic                out_ready;
	logic                res_valid;
	logic                go;

	// Input register: consumed whenever the result register has room.
	assign go = s1_ctl.valid && s1_ctl.ready;

	elr_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.down_ready (out_ready),
		.s1_ctl     (s1_ctl),
		.beat_s1    (beat_s1)
	);

	elr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	elr_fsm #(
		.CAPACITY_MAX (CAPACITY_MAX)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.beat_s1   (beat_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	elr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && res_valid),
		.res       (res),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== tb/tb_enq_ack_link_receiver.sv =====
// Self-checking bench for enq_ack_link_receiver: sends link bytes and ticks with random gaps
// and output stalls, predicts every reply beat in a local protocol model and compares fields.
// Depends on elr_pkg and the enq_ack_link_receiver RTL.
`timescale 1ns / 100ps

module tb_enq_ack_link_receiver;

	localparam int CAP_MAX    = 256;
	localparam int PHASES     = 10;
	localparam int RAND_ITEMS = 1400;
	// Longest timeout that the stimulus will run out tick by tick.
	localparam int TICK_CAP   = 50;

	// Tracks the link protocol state and the reply beats still owed by the block.
	class reply_tracker;
		logic [elr_pkg::TICK_W-1:0] enq_limit;
		logic [elr_pkg::TICK_W-1:0] byte_limit;
		logic [elr_pkg::TICK_W-1:0] eot_limit;
		logic [elr_pkg::CAP_W-1:0]  capacity;
		elr_pkg::phase_t            phase;
		int unsigned                ticks;
		int unsigned                count;
		int unsigned                cap_max;
		elr_pkg::out_beat_t         awaited[$];
		int                         errors;

		function new(int unsigned cap_top);
			cap_max    = cap_top;
			enq_limit  = elr_pkg::RST_ENQ_TIMEOUT;
			byte_limit = elr_pkg::RST_BYTE_TIMEOUT;
			eot_limit  = elr_pkg::RST_EOT_TIMEOUT;
			capacity   = elr_pkg::RST_CAPACITY;
			phase      = elr_pkg::PH_ENQ;
			ticks      = 0;
			count      = 0;
			errors     = 0;
		endfunction

		function void write_reg(logic [elr_pkg::CIDX_W-1:0] idx,
				logic [elr_pkg::CDATA_W-1:0] data);
			case (idx)
				elr_pkg::REG_ENQ_TIMEOUT:  enq_limit = data;
				elr_pkg::REG_BYTE_TIMEOUT: byte_limit = data;
				elr_pkg::REG_EOT_TIMEOUT:  eot_limit = data;
				default:                   capacity = data[elr_pkg::CAP_W-1:0];
			endcase
		endfunction

		// Capacity as the block applies it: zero acts as one, the top is clamped.
		function int unsigned room();
			if (capacity == 0)
				return 1;
			if (capacity > cap_max)
				return cap_max;
			return capacity;
		endfunction

		// Counts one tick, saturating, and tells whether the limit is reached.
		function bit tick_hits(logic [elr_pkg::TICK_W-1:0] limit);
			int unsigned lim;
			lim = (limit == 0) ? 1 : limit;
			if (ticks < 16'hFFFF)
				ticks++;
			return ticks >= lim;
		endfunction

		// Ends the transaction and goes back to waiting for an enquiry.
		function void conclude(inout elr_pkg::out_beat_t r,
				input logic [elr_pkg::STAT_W-1:0] st);
			r.done_res = 1'b1;
			r.status   = st;
			if (st == elr_pkg::ST_OK)
				r.payload_length = count[elr_pkg::BYTE_W-1:0];
			phase = elr_pkg::PH_ENQ;
			ticks = 0;
			count = 0;
		endfunction

		// Works out the reply to one accepted input beat, if it causes one.
		function void take_item(elr_pkg::in_beat_t b);
			elr_pkg::out_beat_t r;
			r = '0;
			if (b.op) begin
				case (phase)
					elr_pkg::PH_ENQ: begin
						if (enq_limit != 0 && tick_hits(enq_limit))
							conclude(r, elr_pkg::ST_TIMEOUT);
					end
					elr_pkg::PH_STX, elr_pkg::PH_TEXT: begin
						if (tick_hits(byte_limit)) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = elr_pkg::CH_EOT;
							conclude(r, elr_pkg::ST_TIMEOUT);
						end
					end
					default: begin
						if (tick_hits(eot_limit))
							conclude(r, elr_pkg::ST_OK);
					end
				endcase
			end else begin
				ticks = 0;
				case (phase)
					elr_pkg::PH_ENQ: begin
						if (b.rx_byte == elr_pkg::CH_EOT) begin
							conclude(r, elr_pkg::ST_CLOSED);
						end else if (b.rx_byte == elr_pkg::CH_ENQ) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = elr_pkg::CH_ACK;
							phase      = elr_pkg::PH_STX;
						end
					end
					elr_pkg::PH_STX: begin
						if (b.rx_byte == elr_pkg::CH_STX) begin
							count = 0;
							phase = elr_pkg::PH_TEXT;
						end else if (b.rx_byte == elr_pkg::CH_EOT) begin
							conclude(r, elr_pkg::ST_ABORTED);
						end else begin
							conclude(r, elr_pkg::ST_INVALID);
						end
					end
					elr_pkg::PH_TEXT: begin
						if (b.rx_byte == elr_pkg::CH_ETX) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = elr_pkg::CH_ACK;
							phase      = elr_pkg::PH_CLOSE;
						end else begin
							r.data_valid = 1'b1;
							r.data_byte  = b.rx_byte;
							r.data_index = count[elr_pkg::BYTE_W-1:0];
							count++;
							// A full buffer is refused and the frame starts over.
							if (count >= room()) begin
								r.tx_valid      = 1'b1;
								r.tx_byte       = elr_pkg::CH_NAK;
								r.frame_discard = 1'b1;
								count           = 0;
								phase           = elr_pkg::PH_STX;
							end
						end
					end
					default: conclude(r, elr_pkg::ST_OK);
				endcase
			end
			if (r.tx_valid || r.data_valid || r.done_res)
				awaited.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			errors++;
			$display("%0t: mismatch: %s", $time, msg);
		endtask

		task compare(string field, logic [elr_pkg::BYTE_W-1:0] got,
				logic [elr_pkg::BYTE_W-1:0] want);
			if (got !== want)
				flag_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
		endtask

		// Checks one accepted reply beat against the oldest one owed.
		task match_reply(elr_pkg::out_beat_t got);
			elr_pkg::out_beat_t want;
			if (awaited.size() == 0) begin
				flag_mismatch($sformatf("reply beat %h arrived with none owed", got));
				return;
			end
			want = awaited.pop_front();
			compare("tx_valid", got.tx_valid, want.tx_valid);
			compare("tx_byte", got.tx_byte, want.tx_byte);
			compare("data_valid", got.data_valid, want.data_valid);
			compare("data_byte", got.data_byte, want.data_byte);
			compare("data_index", got.data_index, want.data_index);
			compare("frame_discard", got.frame_discard, want.frame_discard);
			compare("done_res", got.done_res, want.done_res);
			compare("status", got.status, want.status);
			compare("payload_length", got.payload_length, want.payload_length);
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	elr_pkg::in_beat_t           in_data = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	elr_pkg::out_beat_t          out_data;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [elr_pkg::CIDX_W-1:0]  cfg_index = '0;
	logic [elr_pkg::CDATA_W-1:0] cfg_data = '0;

	reply_tracker board;
	bit           calm = 1'b0;
	int           stall_left = 0;
	int unsigned  sent = 0;

	always #6 clk = ~clk;

	enq_ack_link_receiver #(
		.CAPACITY_MAX(CAP_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Idle length: mostly none, some short, a few long; none in calm stretches.
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int unsigned at_least_one(input logic [elr_pkg::TICK_W-1:0] v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic logic [elr_pkg::BYTE_W-1:0] rand_byte();
		return elr_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [elr_pkg::CDATA_W-1:0] rand_reg(input int unsigned lo,
			input int unsigned hi);
		return elr_pkg::CDATA_W'($urandom_range(lo, hi));
	endfunction

	// Payload byte, now and then a control code other than ETX.
	function automatic logic [elr_pkg::BYTE_W-1:0] payload_byte();
		logic [elr_pkg::BYTE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = elr_pkg::CH_STX;
			1: v = elr_pkg::CH_EOT;
			2: v = elr_pkg::CH_ENQ;
			3: v = elr_pkg::CH_NAK;
			default: begin
				v = rand_byte();
				if (v == elr_pkg::CH_ETX)
					v = 8'hFF;
			end
		endcase
		return v;
	endfunction

	function automatic int frame_len(input int unsigned cap);
		int unsigned top;
		top = cap - 1;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, top);
		return $urandom_range(0, (top < 12) ? top : 12);
	endfunction

	// Both channels are sampled at the edge, before any update of that edge lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.match_reply(out_data);
			if (in_valid && !in_stall)
				board.take_item(in_data);
		end
	end

	// Result-side backpressure in random runs.
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!calm && $urandom_range(0, 99) < 30)
			stall_left = gap_len();
		out_stall <= (stall_left > 0);
	end

	// Offers one input beat after a random gap and holds it until it is taken.
	task automatic drive_item(input elr_pkg::in_beat_t beat);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_byte(input logic [elr_pkg::BYTE_W-1:0] value);
		elr_pkg::in_beat_t b;
		b.op      = 1'b0;
		b.rx_byte = value;
		drive_item(b);
	endtask

	task automatic send_tick();
		elr_pkg::in_beat_t b;
		b.op      = 1'b1;
		b.rx_byte = rand_byte();
		drive_item(b);
	endtask

	// A few ticks, at most the given headroom.
	task automatic some_ticks(input int unsigned headroom);
		int unsigned n;
		n = (headroom > 3) ? 3 : headroom;
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(0, n)) send_tick();
	endtask

	task automatic send_payload(input int n);
		repeat (n) begin
			some_ticks(at_least_one(board.byte_limit) - 1);
			send_byte(payload_byte());
		end
	endtask

	// Holds the sender until every owed reply is in and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [elr_pkg::CIDX_W-1:0] idx,
			input logic [elr_pkg::CDATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic set_regs(input logic [elr_pkg::CDATA_W-1:0] enq, byt, eot, cap);
		drain();
		write_reg(elr_pkg::REG_ENQ_TIMEOUT, enq);
		write_reg(elr_pkg::REG_BYTE_TIMEOUT, byt);
		write_reg(elr_pkg::REG_EOT_TIMEOUT, eot);
		write_reg(elr_pkg::REG_CAPACITY, cap);
		cfg_valid <= 1'b0;
	endtask

	// Brings the link back to waiting for an enquiry, whatever phase it is in.
	task automatic return_to_idle();
		drain();
		case (board.phase)
			elr_pkg::PH_STX:   send_byte(elr_pkg::CH_EOT);
			elr_pkg::PH_TEXT: begin
				send_byte(elr_pkg::CH_ETX);
				send_byte(payload_byte());
			end
			elr_pkg::PH_CLOSE: send_byte(payload_byte());
			default: ;
		endcase
	endtask

	// After the final ACK: a closing byte, or ticks until the close timeout.
	task automatic close_link();
		int unsigned lim_e;
		lim_e = at_least_one(board.eot_limit);
		if ($urandom_range(0, 2) == 0 && lim_e <= TICK_CAP) begin
			repeat (lim_e) send_tick();
		end else begin
			some_ticks(lim_e - 1);
			send_byte(rand_byte());
		end
	endtask

	// One random link transaction; most are complete frames.
	task automatic random_txn();
		int                         kind;
		int unsigned                lim_b;
		int unsigned                cap;
		logic [elr_pkg::BYTE_W-1:0] v;
		lim_b = at_least_one(board.byte_limit);
		cap   = board.room();
		kind  = $urandom_range(0, 99);
		// Overrunning a large buffer is slow, so it is kept rare there.
		if (kind >= 60 && kind < 72 && cap > 64 && $urandom_range(0, 7) != 0)
			kind = 0;

		// Enquiry, with some idle ticks and ignored bytes ahead of it.
		if (kind < 80 || (kind >= 85 && kind < 92)) begin
			some_ticks((board.enq_limit == 0) ? 3 : board.enq_limit - 1);
			if ($urandom_range(0, 4) == 0) begin
				v = rand_byte();
				if (v == elr_pkg::CH_ENQ || v == elr_pkg::CH_EOT)
					v = 8'h00;
				send_byte(v);
			end
			send_byte(elr_pkg::CH_ENQ);
			some_ticks(lim_b - 1);
		end

		if (kind < 60) begin
			send_byte(elr_pkg::CH_STX);
			send_payload(frame_len(cap));
			send_byte(elr_pkg::CH_ETX);
			close_link();
		end else if (kind < 72) begin
			// Fill the buffer to get NAK, then send a good frame.
			send_byte(elr_pkg::CH_STX);
			send_payload(cap);
			send_byte(elr_pkg::CH_STX);
			send_payload(frame_len(cap));
			send_byte(elr_pkg::CH_ETX);
			close_link();
		end else if (kind < 80) begin
			// Let the byte timer run out, before STX or within the payload.
			if (lim_b > TICK_CAP) begin
				send_byte(elr_pkg::CH_EOT);
			end else begin
				if ($urandom_range(0, 1)) begin
					send_byte(elr_pkg::CH_STX);
					send_payload(frame_len(cap));
				end
				repeat (lim_b) send_tick();
			end
		end else if (kind < 85) begin
			if (board.enq_limit != 0 && board.enq_limit <= TICK_CAP)
				repeat (board.enq_limit) send_tick();
			else
				send_byte(elr_pkg::CH_EOT);
		end else if (kind < 92) begin
			// Abort or a wrong byte where STX is due.
			if ($urandom_range(0, 1)) begin
				send_byte(elr_pkg::CH_EOT);
			end else begin
				v = rand_byte();
				if (v == elr_pkg::CH_STX)
					v = elr_pkg::CH_ENQ;
				send_byte(v);
			end
		end else if (kind < 96) begin
			send_byte(elr_pkg::CH_EOT);
		end else begin
			// Loose mix of control codes, bytes and ticks.
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 5))
					0: send_tick();
					1: send_byte(elr_pkg::CH_STX);
					2: send_byte(elr_pkg::CH_ETX);
					3: send_byte(elr_pkg::CH_EOT);
					4: send_byte(elr_pkg::CH_ENQ);
					default: send_byte(rand_byte());
				endcase
			end
			return_to_idle();
		end
	endtask

	initial begin
		int unsigned base;
		board = new(CAP_MAX);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle: ticks and plain bytes are ignored, EOT closes.
		send_tick();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(elr_pkg::CH_EOT);
		// A good frame with extreme and control-code payload bytes.
		send_byte(elr_pkg::CH_ENQ);
		send_tick();
		send_byte(elr_pkg::CH_STX);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(elr_pkg::CH_ENQ);
		send_byte(elr_pkg::CH_EOT);
		send_byte(elr_pkg::CH_ETX);
		send_byte(elr_pkg::CH_NAK);
		// Wrong byte, then EOT, where STX is due.
		send_byte(elr_pkg::CH_ENQ);
		send_byte(8'h41);
		send_byte(elr_pkg::CH_ENQ);
		send_byte(elr_pkg::CH_EOT);
		// Capacity lowered below the bytes already taken in an open frame.
		send_byte(elr_pkg::CH_ENQ);
		send_byte(elr_pkg::CH_STX);
		repeat (3) send_byte(payload_byte());
		drain();
		write_reg(elr_pkg::REG_CAPACITY, 16'd2);
		cfg_valid <= 1'b0;
		send_byte(payload_byte());
		return_to_idle();

		// Random traffic over a series of register settings.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_regs(elr_pkg::RST_ENQ_TIMEOUT, elr_pkg::RST_BYTE_TIMEOUT,
						elr_pkg::RST_EOT_TIMEOUT,
						elr_pkg::CDATA_W'(elr_pkg::RST_CAPACITY));
				1: set_regs(16'd5, 16'd4, 16'd3, 16'd4);
				2: set_regs(16'd0, 16'd1, 16'd1, 16'd1);
				3: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256);
				4: set_regs(16'd1, 16'd0, 16'd0, 16'd0);
				5: set_regs(16'd3, 16'd8, 16'd6, 16'd511);
				6: set_regs(16'd0, 16'd20, 16'd10, 16'hFE10);
				7: set_regs(16'd12, 16'd6, 16'd5, 16'd2);
				8: set_regs(16'd40, 16'd2, 16'd1, 16'd255);
				default: set_regs(rand_reg(0, 50), rand_reg(1, 30),
						rand_reg(1, 30), rand_reg(0, 511));
			endcase
			calm = ($urandom_range(0, 3) == 0);
			base = sent;
			while (sent < base + RAND_ITEMS / PHASES)
				random_txn();
		end

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("tb_enq_ack_link_receiver passed");
		else
			$display("tb_enq_ack_link_receiver failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#40_000_000;
		$display("tb_enq_ack_link_receiver failed");
		$finish;
	end

endmodule
